>>> sv/bkre_pkg.sv
package bkre_pkg;

  // Fixed report layout
  localparam int IN_SLOTS = 6;
  localparam int MOD_BITS = 8;
  localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
  localparam logic [7:0] RESERVED_MAX = 8'd3;

  typedef struct packed {
    logic       cmd;
    logic       too_short;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_t;

  typedef struct packed {
    logic [7:0] key_usage;
    logic       is_press;
    logic [7:0] current_modifiers;
    logic       last_event;
  } out_t;

  // Microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_WAIT   = 3'd0;
  localparam step_t ST_MOD    = 3'd1;
  localparam step_t ST_PRESS  = 3'd2;
  localparam step_t ST_REL    = 3'd3;
  localparam step_t ST_FLUSH  = 3'd4;
  localparam step_t ST_RESYNC = 3'd5;

  typedef enum logic [1:0] {
    SRC_MOD   = 2'd0,
    SRC_PRESS = 2'd1,
    SRC_REL   = 2'd2
  } ev_src_t;

  // One control word per step
  typedef struct packed {
    logic    accept;  // take an input transaction, branch on its kind
    logic    scan;    // walk idx over the source, loop until its last element
    ev_src_t src;     // what the scan compares
    logic    flush;   // drain the pending event as last, then commit state
    logic    resync;  // clear history
    step_t   next;    // fall-through target
  } uword_t;

  // Sequencer <-> event buffer
  typedef struct packed {
    logic push;
    logic flush;
  } evq_ctl_t;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w = '{accept: 1'b0, scan: 1'b0, src: SRC_MOD, flush: 1'b0, resync: 1'b0,
          next: ST_WAIT};
    unique case (s)
      ST_WAIT:   begin w.accept = 1'b1; w.next = ST_MOD; end
      ST_MOD:    begin w.scan = 1'b1; w.src = SRC_MOD;   w.next = ST_PRESS; end
      ST_PRESS:  begin w.scan = 1'b1; w.src = SRC_PRESS; w.next = ST_REL; end
      ST_REL:    begin w.scan = 1'b1; w.src = SRC_REL;   w.next = ST_FLUSH; end
      ST_FLUSH:  begin w.flush = 1'b1;  w.next = ST_WAIT; end
      ST_RESYNC: begin w.resync = 1'b1; w.next = ST_WAIT; end
      default:   w.next = ST_WAIT;
    endcase
    return w;
  endfunction

endpackage

>>> sv/bkre_evq.sv
module bkre_evq import bkre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  evq_ctl_t ctl,
  input  out_t     ev,
  output logic     take_ok,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  logic pend_v_r, pend_v_nxt;
  out_t pend_r, pend_nxt;
  logic out_v_r, out_v_nxt;
  out_t out_r, out_nxt;
  logic out_free;

  assign out_free  = !out_v_r || out_ready;
  assign take_ok   = !pend_v_r || out_free;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Hold one event back so the final one of a report can be tagged
  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (pend_v_r && out_free && (ctl.push || ctl.flush)) begin
      out_v_nxt           = 1'b1;
      out_nxt             = pend_r;
      out_nxt.last_event  = ctl.flush;
      pend_v_nxt          = 1'b0;
    end
    if (ctl.push && take_ok) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

>>> sv/boot_keyboard_report_to_key_events.sv
// Boot keyboard report differ.
// Input channel (in_valid/in_ready, in_data): one transaction is a boot
// keyboard report or a resync command. Output channel (out_valid/out_ready,
// out_data): key events, modifier changes first, then presses, then
// releases; last_event marks the final event of a report.
// A microcoded sequencer walks the modifier bits and the key slots one per
// cycle unless a stalled receiver holds it; a full report runs one accept
// step, eight modifier steps, KEY_SLOTS press steps, KEY_SLOTS release steps
// and one drain/commit step before the next report can be taken. A resync
// runs the accept and resync steps, a short report only the accept step, the
// first report after reset or resync the accept and drain/commit steps.
// Events leave through a one-deep hold stage and an output register: an
// event is held until the next one is found or the drain step runs.
// Reset: history cleared, next report is silent, both channels empty.
// A stalled receiver backs up into the sequencer, which holds its step
// until the event can move; nothing is dropped.
module boot_keyboard_report_to_key_events import bkre_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IDX_W  = (KEY_SLOTS > MOD_BITS) ? $clog2(KEY_SLOTS) : 3;
  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  step_t              step_r;
  logic [IDX_W-1:0]   idx_r;
  logic               awaiting_r;
  logic [7:0]         cur_mods_r, prev_mods_r;
  logic [7:0]         cur_keys_r  [KEY_SLOTS];
  logic [7:0]         prev_keys_r [KEY_SLOTS];
  logic [7:0]         in_keys     [KEY_SLOTS];

  uword_t             uw;
  logic               accept;
  logic [SLOT_W-1:0]  slot;
  logic [2:0]         bit_sel;
  logic [7:0]         a_key;
  logic [KEY_SLOTS-1:0] match;
  logic               present;
  logic               cand;
  logic               take_ok;
  logic               stall;
  logic [IDX_W-1:0]   limit;
  logic               at_end;
  evq_ctl_t           evq_ctl;
  out_t               ev;

  assign uw       = ucode_rom(step_r);
  assign in_ready = uw.accept;
  assign accept   = in_valid && uw.accept;

  // Map input slots onto the configured slot count; extra slots read as zero
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
    if (i == 0)      begin : g0 assign in_keys[i] = in_data.key_slot_0; end
    else if (i == 1) begin : g1 assign in_keys[i] = in_data.key_slot_1; end
    else if (i == 2) begin : g2 assign in_keys[i] = in_data.key_slot_2; end
    else if (i == 3) begin : g3 assign in_keys[i] = in_data.key_slot_3; end
    else if (i == 4) begin : g4 assign in_keys[i] = in_data.key_slot_4; end
    else if (i == 5) begin : g5 assign in_keys[i] = in_data.key_slot_5; end
    else             begin : gz assign in_keys[i] = 8'd0; end
  end

  // Select the element under test and search the other report for it
  assign slot    = idx_r[SLOT_W-1:0];
  assign bit_sel = idx_r[2:0];
  assign a_key   = (uw.src == SRC_PRESS) ? cur_keys_r[slot] : prev_keys_r[slot];

  always_comb begin
    for (int j = 0; j < KEY_SLOTS; j++) begin
      match[j] = ((uw.src == SRC_PRESS) ? prev_keys_r[j] : cur_keys_r[j]) == a_key;
    end
  end
  assign present = |match;

  always_comb begin
    ev.current_modifiers = cur_mods_r;
    ev.last_event        = 1'b0;
    if (uw.src == SRC_MOD) begin
      cand          = uw.scan && (cur_mods_r[bit_sel] != prev_mods_r[bit_sel]);
      ev.key_usage  = MOD_USAGE_BASE + {5'd0, bit_sel};
      ev.is_press   = cur_mods_r[bit_sel];
    end else begin
      cand          = uw.scan && (a_key > RESERVED_MAX) && !present;
      ev.key_usage  = a_key;
      ev.is_press   = (uw.src == SRC_PRESS);
    end
  end

  assign stall         = cand && !take_ok;
  assign limit         = (uw.src == SRC_MOD) ? IDX_W'(MOD_BITS - 1) : IDX_W'(KEY_SLOTS - 1);
  assign at_end        = (idx_r == limit);
  assign evq_ctl.push  = cand;
  assign evq_ctl.flush = uw.flush;

  // Step counter, loop index and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_WAIT;
      idx_r       <= '0;
      awaiting_r  <= 1'b1;
      prev_mods_r <= 8'd0;
      for (int j = 0; j < KEY_SLOTS; j++) prev_keys_r[j] <= 8'd0;
    end else begin
      if (accept) begin
        idx_r <= '0;
        priority if (in_data.cmd)       step_r <= ST_RESYNC;
        else if (in_data.too_short)     step_r <= ST_WAIT;
        else if (awaiting_r)            step_r <= ST_FLUSH;
        else                            step_r <= uw.next;
      end else if (uw.scan && !stall) begin
        if (at_end) begin
          idx_r  <= '0;
          step_r <= uw.next;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end else if (uw.flush && take_ok) begin
        prev_mods_r <= cur_mods_r;
        for (int j = 0; j < KEY_SLOTS; j++) prev_keys_r[j] <= cur_keys_r[j];
        awaiting_r  <= 1'b0;
        step_r      <= uw.next;
      end else if (uw.resync) begin
        prev_mods_r <= 8'd0;
        for (int j = 0; j < KEY_SLOTS; j++) prev_keys_r[j] <= 8'd0;
        awaiting_r  <= 1'b1;
        step_r      <= uw.next;
      end else if (!uw.accept && !uw.scan && !uw.flush) begin
        step_r <= ST_WAIT;
      end
    end
  end

  // Latch the current report
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mods_r <= in_data.modifier_bits;
      for (int j = 0; j < KEY_SLOTS; j++) cur_keys_r[j] <= in_keys[j];
    end
  end

  bkre_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (evq_ctl),
    .ev        (ev),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_resync_branch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd) |=> (step_r == ST_RESYNC))
    else $error("resync command did not branch to the resync step");

  a_silent_first: assert property (@(posedge clk) disable iff (!rst_n)
    uw.scan |-> !awaiting_r)
    else $error("scan running while history is not yet recorded");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uw.scan |-> (idx_r <= limit))
    else $error("scan index past the end of its source");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> ($stable(step_r) && $stable(idx_r)))
    else $error("sequencer advanced while the event buffer was full");

endmodule

>>> tb/sv/boot_keyboard_report_to_key_events_tb.sv
module boot_keyboard_report_to_key_events_tb import bkre_pkg::*; ();

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;
  localparam int MAX_EVENTS = 20;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PRINT_CAP = 100;

  typedef logic [IN_SLOTS-1:0][7:0] key_row_t;

  typedef struct {
    in_t item;
    bit  drain_first;
  } queued_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  queued_report_t report_backlog[$];
  out_t owed_events[$];
  int items_queued = 0;
  int items_taken = 0;
  int events_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic calm_phase = 1'b0;

  // Mirror of the block's report history
  logic [7:0] prior_mods = '0;
  key_row_t prior_keys = '0;
  logic history_blank = 1'b1;

  boot_keyboard_report_to_key_events DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  function automatic bit key_held(logic [7:0] k, key_row_t row);
    for (int s = 0; s < IN_SLOTS; s++) begin
      if (row[s] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Diff one accepted transaction against history and owe its key events
  task automatic predict_key_events(in_t rpt);
    key_row_t now_keys;
    out_t batch[MAX_EVENTS];
    int n;
    n = 0;
    if (rpt.cmd == CMD_RESYNC) begin
      prior_mods = '0;
      prior_keys = '0;
      history_blank = 1'b1;
      return;
    end
    if (rpt.too_short) return;
    now_keys = {rpt.key_slot_5, rpt.key_slot_4, rpt.key_slot_3,
                rpt.key_slot_2, rpt.key_slot_1, rpt.key_slot_0};
    if (!history_blank) begin
      for (int b = 0; b < MOD_BITS; b++) begin
        if (prior_mods[b] != rpt.modifier_bits[b]) begin
          batch[n] = '{key_usage: MOD_USAGE_BASE + 8'(b), is_press: rpt.modifier_bits[b],
                       current_modifiers: rpt.modifier_bits, last_event: 1'b0};
          n++;
        end
      end
      for (int s = 0; s < IN_SLOTS; s++) begin
        if (now_keys[s] > RESERVED_MAX && !key_held(now_keys[s], prior_keys)) begin
          batch[n] = '{key_usage: now_keys[s], is_press: 1'b1,
                       current_modifiers: rpt.modifier_bits, last_event: 1'b0};
          n++;
        end
      end
      for (int s = 0; s < IN_SLOTS; s++) begin
        if (prior_keys[s] > RESERVED_MAX && !key_held(prior_keys[s], now_keys)) begin
          batch[n] = '{key_usage: prior_keys[s], is_press: 1'b0,
                       current_modifiers: rpt.modifier_bits, last_event: 1'b0};
          n++;
        end
      end
      if (n > 0) batch[n-1].last_event = 1'b1;
      for (int e = 0; e < n; e++) owed_events.push_back(batch[e]);
    end
    prior_mods = rpt.modifier_bits;
    prior_keys = now_keys;
    history_blank = 1'b0;
  endtask

  function automatic in_t make_item(logic cmd, logic short_flag, logic [7:0] mods,
                                    key_row_t keys);
    in_t it;
    it.cmd = cmd;
    it.too_short = short_flag;
    it.modifier_bits = mods;
    it.key_slot_0 = keys[0];
    it.key_slot_1 = keys[1];
    it.key_slot_2 = keys[2];
    it.key_slot_3 = keys[3];
    it.key_slot_4 = keys[4];
    it.key_slot_5 = keys[5];
    return it;
  endfunction

  function automatic key_row_t random_row();
    key_row_t row;
    for (int s = 0; s < IN_SLOTS; s++) row[s] = 8'($urandom_range(255));
    return row;
  endfunction

  // Mostly a small pool of real keys so reports overlap; some reserved and wide codes
  function automatic logic [7:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return 8'd0;
    if (roll < 28) return 8'($urandom_range(3));
    if (roll < 80) return 8'($urandom_range(24, 4));
    return 8'($urandom_range(255));
  endfunction

  task automatic enqueue(in_t it, bit drain);
    queued_report_t q;
    q.item = it;
    q.drain_first = drain;
    report_backlog.push_back(q);
    items_queued++;
  endtask

  // Drive input transactions from the backlog
  always @(posedge clk) begin : drive_reports
    bit skip;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_key_events(in_data);
        items_taken++;
      end
      calm_phase <= (items_taken >= 180) && (items_taken < 260);
      skip = !calm_phase && ($urandom_range(99) < 15);
      if (!in_valid || in_ready) begin
        if (report_backlog.size() != 0 && !skip &&
            !(report_backlog[0].drain_first && owed_events.size() != 0)) begin
          in_data <= report_backlog[0].item;
          in_valid <= 1'b1;
          report_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each event transaction against the oldest owed one
  always @(posedge clk) begin : watch_events
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_events.size() == 0) begin
          note_failure($sformatf("event %0d unexpected, usage %02h press %0b",
                                 events_seen, out_data.key_usage, out_data.is_press));
        end else begin
          want = owed_events.pop_front();
          if (out_data.key_usage !== want.key_usage)
            note_failure($sformatf("event %0d key_usage got %02h want %02h",
                                   events_seen, out_data.key_usage, want.key_usage));
          if (out_data.is_press !== want.is_press)
            note_failure($sformatf("event %0d is_press got %0b want %0b",
                                   events_seen, out_data.is_press, want.is_press));
          if (out_data.current_modifiers !== want.current_modifiers)
            note_failure($sformatf("event %0d current_modifiers got %02h want %02h",
                                   events_seen, out_data.current_modifiers,
                                   want.current_modifiers));
          if (out_data.last_event !== want.last_event)
            note_failure($sformatf("event %0d last_event got %0b want %0b",
                                   events_seen, out_data.last_event, want.last_event));
        end
        events_seen++;
      end
      out_ready <= calm_phase || ($urandom_range(99) >= 15);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    key_row_t walk_keys;
    logic [7:0] walk_mods;
    int roll;
    bit drain;

    // Directed: short report before any history, then the silent first report
    enqueue(make_item(CMD_REPORT, 1'b1, 8'h3C, random_row()), 1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, '0), 1'b0);
    // All modifiers and six presses, then the twenty-event worst case
    enqueue(make_item(CMD_REPORT, 1'b0, 8'hFF, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04}),
            1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, {8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A}),
            1'b0);
    // No change
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, {8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A}),
            1'b0);
    // Reserved codes and the top code
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, {8'hFF, 8'h0A, 8'h03, 8'h02, 8'h01, 8'h00}),
            1'b0);
    // Repeated codes across slots
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, {8'h00, 8'h06, 8'h06, 8'h05, 8'h05, 8'h05}),
            1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, '0), 1'b0);
    // Short report must leave history alone
    enqueue(make_item(CMD_REPORT, 1'b1, 8'hAA, {8'h16, 8'h15, 8'h14, 8'h13, 8'h12, 8'h11}),
            1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, '0), 1'b1);
    // Resync ignores too_short; next report is silent
    enqueue(make_item(CMD_RESYNC, 1'b1, 8'hC3, random_row()), 1'b1);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h55, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04}),
            1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'hAA, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04}),
            1'b0);
    // Back-to-back resyncs
    enqueue(make_item(CMD_RESYNC, 1'b0, 8'h00, '0), 1'b0);
    enqueue(make_item(CMD_RESYNC, 1'b0, 8'hFF, '1), 1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h80, {8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF}),
            1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, {8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF}),
            1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h01, '0), 1'b0);
    enqueue(make_item(CMD_RESYNC, 1'b0, 8'h00, '0), 1'b0);
    enqueue(make_item(CMD_REPORT, 1'b0, 8'h00, '0), 1'b0);

    // Random: mostly a typing session that evolves report by report
    walk_keys = '0;
    walk_mods = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(99);
      drain = (i % 97 == 50);
      if (roll < 5) begin
        enqueue(make_item(CMD_RESYNC, 1'($urandom_range(1)), 8'($urandom_range(255)),
                          random_row()), drain);
      end else if (roll < 12) begin
        enqueue(make_item(CMD_REPORT, 1'b1, 8'($urandom_range(255)), random_row()), drain);
      end else if (roll < 20) begin
        walk_mods = 8'($urandom_range(255));
        walk_keys = random_row();
        enqueue(make_item(CMD_REPORT, 1'b0, walk_mods, walk_keys), drain);
      end else begin
        if ($urandom_range(99) < 40)
          walk_mods ^= 8'($urandom_range(255)) & 8'($urandom_range(255));
        for (int s = 0; s < IN_SLOTS; s++) begin
          if ($urandom_range(99) < 25) walk_keys[s] = pick_key();
        end
        enqueue(make_item(CMD_REPORT, 1'b0, walk_mods, walk_keys), drain);
      end
    end

    // Reset, then let the driver run the backlog
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken != items_queued) @(posedge clk);
    while (owed_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
